// ===== sv/stkagg_pkg.sv =====
// ----------------------------------------------------------------------------
// Stack with aggregate queries: shared package
// Types, sizes and command and status codes used by the scan unit and the stack.
// ----------------------------------------------------------------------------
package stkagg_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int PTR_W       = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int SUM_W       = 40;
    localparam int LARGEST_W   = 31;
    localparam int COUNT_W     = 9;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_QUERY = 2'd2
    } command_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } status_t;

    typedef struct packed {
        logic clear;
        logic enable;
    } scan_ctrl_t;

endpackage

// ===== sv/stkagg_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One access per cycle at one address; a write also reads the old data, and the read data is registered.
// ----------------------------------------------------------------------------
module stkagg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== sv/stkagg_scan.sv =====
// ----------------------------------------------------------------------------
// Stack scan unit
// Compares one stored entry per cycle while enabled, keeping the running maximum
// (floored at zero) and the number of entries equal to the key.
// ----------------------------------------------------------------------------
module stkagg_scan (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  stkagg_pkg::scan_ctrl_t                  ctrl,
    input  logic signed [stkagg_pkg::DATA_W-1:0]    data,
    input  logic signed [stkagg_pkg::DATA_W-1:0]    key,
    output logic [stkagg_pkg::LARGEST_W-1:0]        max_val,
    output logic [stkagg_pkg::PTR_W-1:0]            match_cnt
);

    import stkagg_pkg::*;

    logic [LARGEST_W-1:0] max_reg;
    logic [LARGEST_W-1:0] max_next;
    logic [PTR_W-1:0]     cnt_reg;
    logic [PTR_W-1:0]     cnt_next;

    always_comb
    begin
        max_next = max_reg;
        cnt_next = cnt_reg;
        if (ctrl.clear)
        begin
            max_next = '0;
            cnt_next = '0;
        end
        else if (ctrl.enable)
        begin
            if (data > $signed({1'b0, max_reg}))
            begin
                max_next = data[LARGEST_W-1:0];
            end
            if (data == key)
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            max_reg <= max_next;
            cnt_reg <= cnt_next;
        end
    end

    assign max_val   = max_reg;
    assign match_cnt = cnt_reg;

endmodule

// ===== sv/stack_with_aggregate_queries.sv =====
// ----------------------------------------------------------------------------
// Stack with aggregate queries
// Bounded LIFO stack of signed 32-bit values reporting occupancy, sum,
// largest entry and, on request, the count of entries equal to a key.
//
//   Channel   Handshake       Payload
//   request   start / busy    command, value
//   result    done (strobe)   popped_value, status, is_empty, occupancy,
//                             total_sum, largest, match_count
//
// Push, a rejected push or pop, a query on an empty stack and an unused
// command finish in the idle state, and a pop that empties the stack
// finishes in the pop-data state. Any other pop or query runs a scan over
// the entry RAM, one entry per cycle through its single read port, so its
// length grows with the occupancy.
// The result strobe comes the cycle after the work ends and cannot stall.
// Reset clears the pointer, sum and largest entry; the RAM is not cleared.
// ----------------------------------------------------------------------------
module stack_with_aggregate_queries (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     start,
    output logic                                     busy,
    input  logic [stkagg_pkg::CMD_W-1:0]             command,
    input  logic signed [stkagg_pkg::DATA_W-1:0]     value,
    output logic                                     done,
    output logic signed [stkagg_pkg::DATA_W-1:0]     popped_value,
    output logic [stkagg_pkg::STATUS_W-1:0]          status,
    output logic                                     is_empty,
    output logic [stkagg_pkg::COUNT_W-1:0]           occupancy,
    output logic signed [stkagg_pkg::SUM_W-1:0]      total_sum,
    output logic [stkagg_pkg::LARGEST_W-1:0]         largest,
    output logic [stkagg_pkg::COUNT_W-1:0]           match_count
);

    import stkagg_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP_DATA,
        S_SCAN
    } state_t;

    state_t                    state_reg, state_next;
    logic [PTR_W-1:0]          top_reg, top_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic [LARGEST_W-1:0]      largest_reg, largest_next;
    logic signed [DATA_W-1:0]  key_reg, key_next;
    logic signed [DATA_W-1:0]  pop_val_reg, pop_val_next;
    logic                      query_reg, query_next;
    logic [PTR_W-1:0]          idx_reg, idx_next;
    logic                      vld_reg, vld_next;

    logic                      done_reg, done_next;
    logic signed [DATA_W-1:0]  popped_reg, popped_next;
    status_t                   status_reg, status_next;
    logic                      empty_reg, empty_next;
    logic [COUNT_W-1:0]        occ_reg, occ_next;
    logic signed [SUM_W-1:0]   tsum_reg, tsum_next;
    logic [LARGEST_W-1:0]      lout_reg, lout_next;
    logic [COUNT_W-1:0]        match_reg, match_next;

    logic                      ram_we;
    logic [ADDR_W-1:0]         ram_addr;
    logic [DATA_W-1:0]         ram_rdata;
    logic signed [DATA_W-1:0]  rdata_s;

    scan_ctrl_t                scan_ctrl;
    logic [LARGEST_W-1:0]      scan_max;
    logic [PTR_W-1:0]          scan_cnt;

    logic signed [DATA_W-1:0]  pop_o;
    status_t                   st_o;
    logic [PTR_W-1:0]          mc_o;

    assign rdata_s = $signed(ram_rdata);

    stkagg_ram #(
        .WIDTH(DATA_W),
        .DEPTH(STACK_DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(value),
        .rdata(ram_rdata)
    );

    stkagg_scan u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (scan_ctrl),
        .data     (rdata_s),
        .key      (key_reg),
        .max_val  (scan_max),
        .match_cnt(scan_cnt)
    );

    always_comb
    begin
        state_next   = state_reg;
        top_next     = top_reg;
        sum_next     = sum_reg;
        largest_next = largest_reg;
        key_next     = key_reg;
        pop_val_next = pop_val_reg;
        query_next   = query_reg;
        idx_next     = idx_reg;
        vld_next     = vld_reg;
        done_next    = 1'b0;
        ram_we       = 1'b0;
        ram_addr     = idx_reg[ADDR_W-1:0];
        scan_ctrl    = '0;
        pop_o        = '0;
        st_o         = ST_OK;
        mc_o         = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (command_t'(command))
                        CMD_PUSH:
                        begin
                            done_next = 1'b1;
                            if (top_reg == PTR_W'(STACK_DEPTH))
                            begin
                                st_o = ST_OVERFLOW;
                            end
                            else
                            begin
                                ram_we   = 1'b1;
                                ram_addr = top_reg[ADDR_W-1:0];
                                top_next = top_reg + 1'b1;
                                sum_next = sum_reg + SUM_W'(value);
                                if (value > $signed({1'b0, largest_reg}))
                                begin
                                    largest_next = value[LARGEST_W-1:0];
                                end
                            end
                        end
                        CMD_POP:
                        begin
                            if (top_reg == '0)
                            begin
                                done_next = 1'b1;
                                st_o      = ST_UNDERFLOW;
                            end
                            else
                            begin
                                ram_addr   = ADDR_W'(top_reg - 1'b1);
                                top_next   = top_reg - 1'b1;
                                state_next = S_POP_DATA;
                            end
                        end
                        CMD_QUERY:
                        begin
                            key_next = value;
                            if (top_reg == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                scan_ctrl.clear = 1'b1;
                                query_next      = 1'b1;
                                idx_next        = '0;
                                vld_next        = 1'b0;
                                state_next      = S_SCAN;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_POP_DATA:
            begin
                pop_val_next = rdata_s;
                sum_next     = sum_reg - SUM_W'(rdata_s);
                if (top_reg == '0)
                begin
                    largest_next = '0;
                    done_next    = 1'b1;
                    pop_o        = rdata_s;
                    state_next   = S_IDLE;
                end
                else
                begin
                    scan_ctrl.clear = 1'b1;
                    query_next      = 1'b0;
                    idx_next        = '0;
                    vld_next        = 1'b0;
                    state_next      = S_SCAN;
                end
            end
            S_SCAN:
            begin
                scan_ctrl.enable = vld_reg;
                if (idx_reg < top_reg)
                begin
                    idx_next = idx_reg + 1'b1;
                    vld_next = 1'b1;
                end
                else
                begin
                    vld_next = 1'b0;
                    if (!vld_reg)
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                        if (query_reg)
                        begin
                            mc_o = scan_cnt;
                        end
                        else
                        begin
                            pop_o        = pop_val_reg;
                            largest_next = scan_max;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        popped_next = popped_reg;
        status_next = status_reg;
        empty_next  = empty_reg;
        occ_next    = occ_reg;
        tsum_next   = tsum_reg;
        lout_next   = lout_reg;
        match_next  = match_reg;
        if (done_next)
        begin
            popped_next = pop_o;
            status_next = st_o;
            empty_next  = (top_next == '0);
            occ_next    = COUNT_W'(top_next);
            tsum_next   = sum_next;
            lout_next   = largest_next;
            match_next  = COUNT_W'(mc_o);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            top_reg     <= '0;
            sum_reg     <= '0;
            largest_reg <= '0;
            key_reg     <= '0;
            pop_val_reg <= '0;
            query_reg   <= 1'b0;
            idx_reg     <= '0;
            vld_reg     <= 1'b0;
            done_reg    <= 1'b0;
            popped_reg  <= '0;
            status_reg  <= ST_OK;
            empty_reg   <= 1'b1;
            occ_reg     <= '0;
            tsum_reg    <= '0;
            lout_reg    <= '0;
            match_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            top_reg     <= top_next;
            sum_reg     <= sum_next;
            largest_reg <= largest_next;
            key_reg     <= key_next;
            pop_val_reg <= pop_val_next;
            query_reg   <= query_next;
            idx_reg     <= idx_next;
            vld_reg     <= vld_next;
            done_reg    <= done_next;
            popped_reg  <= popped_next;
            status_reg  <= status_next;
            empty_reg   <= empty_next;
            occ_reg     <= occ_next;
            tsum_reg    <= tsum_next;
            lout_reg    <= lout_next;
            match_reg   <= match_next;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign popped_value = popped_reg;
    assign status       = status_reg;
    assign is_empty     = empty_reg;
    assign occupancy    = occ_reg;
    assign total_sum    = tsum_reg;
    assign largest      = lout_reg;
    assign match_count  = match_reg;

endmodule
